FILE: rtl/bolp_pkg.sv
`timescale 1ns / 1ps

package bolp_pkg;

  // longest key or value in bytes, and bytes kept for the module name
  localparam int TOKEN_MAX      = 31;
  localparam int NAME_BYTES     = 32;
  // name bytes carried on the result (four 64-bit words)
  localparam int OUT_NAME_BYTES = 32;

  localparam int LEN_W = $clog2(TOKEN_MAX + 1);
  localparam int IDX_W = $clog2(TOKEN_MAX);

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // byte classes
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_DATA = 2'd0;
  localparam kind_t KIND_EQ   = 2'd1;
  localparam kind_t KIND_SEP  = 2'd2;
  localparam kind_t KIND_END  = 2'd3;

  // result events
  typedef logic [1:0] event_t;
  localparam event_t EV_UNKNOWN = 2'd0;
  localparam event_t EV_ACCEPT  = 2'd1;
  localparam event_t EV_REJECT  = 2'd2;

  // special characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_EQ    = 8'h3d;

  localparam int KW_KERNEL_LEN  = 8;
  localparam int KW_VERBOSE_LEN = 7;
  localparam int KW_VMMAP_LEN   = 12;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } beat_t;

  typedef struct packed {
    logic  valid;
    beat_t beat;
  } q_head_t;

  typedef struct packed {
    event_t                      ev;
    logic                        verbose;
    logic                        vmmap;
    logic [OUT_NAME_BYTES*8-1:0] name;
  } res_t;

  // "kernel64"
  function automatic logic [7:0] kw_kernel_byte(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0: ch = 8'h6b;
      3'd1: ch = 8'h65;
      3'd2: ch = 8'h72;
      3'd3: ch = 8'h6e;
      3'd4: ch = 8'h65;
      3'd5: ch = 8'h6c;
      3'd6: ch = 8'h36;
      3'd7: ch = 8'h34;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "verbose-mmap", whose first seven bytes are "verbose"
  function automatic logic [7:0] kw_vmmap_byte(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:  ch = 8'h76;
      4'd1:  ch = 8'h65;
      4'd2:  ch = 8'h72;
      4'd3:  ch = 8'h62;
      4'd4:  ch = 8'h6f;
      4'd5:  ch = 8'h73;
      4'd6:  ch = 8'h65;
      4'd7:  ch = 8'h2d;
      4'd8:  ch = 8'h6d;
      4'd9:  ch = 8'h6d;
      4'd10: ch = 8'h61;
      4'd11: ch = 8'h70;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

FILE: rtl/bolp_front.sv
`timescale 1ns / 1ps

module bolp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data,
  output bolp_pkg::q_head_t head,
  input  logic              pop
);
  import bolp_pkg::*;

  beat_t             q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  kind_t             kind;
  logic              push;

  // byte class
  always_comb begin
    priority if (in_data == CH_NUL)                        kind = KIND_END;
    else if (in_data == CH_SPACE || in_data == CH_SEMI)    kind = KIND_SEP;
    else if (in_data == CH_EQ)                             kind = KIND_EQ;
    else                                                   kind = KIND_DATA;
  end

  assign in_ready = (count != QCNT_W'(QDEPTH));
  assign push     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{kind: kind, data: in_data};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head.valid = (count != '0);
  assign head.beat  = q[rd_ptr];

endmodule

FILE: rtl/bolp_back.sv
`timescale 1ns / 1ps

module bolp_back (
  input  logic              clk,
  input  logic              rst,
  input  bolp_pkg::q_head_t head,
  output logic              pop,
  output logic              res_valid,
  input  logic              res_ready,
  output bolp_pkg::res_t    res
);
  import bolp_pkg::*;

  logic [LEN_W-1:0] key_len;
  logic [LEN_W-1:0] val_len;
  logic             in_val;
  logic             seen_v;
  logic             seen_vm;
  logic             skipping;
  logic             match_k;   // key so far is a prefix of kernel64
  logic             match_vm;  // key so far is a prefix of verbose-mmap
  logic [7:0]       value_store [TOKEN_MAX];
  logic [7:0]       module_name [NAME_BYTES];

  kind_t            kind;
  logic [7:0]       ch;
  logic             apply;
  logic             hit_k;
  logic             hit_v;
  logic             hit_vm;
  logic             unknown;
  logic             key_full;
  logic             val_full;
  logic             emit;
  event_t           ev;
  logic             do_clear;
  logic [7:0]       name_copy  [NAME_BYTES];
  logic [7:0]       name_after [NAME_BYTES];
  res_t             res_next;

  assign kind = head.beat.kind;
  assign ch   = head.beat.data;
  assign pop  = head.valid && (!res_valid || res_ready);

  // token end decode
  always_comb begin
    apply    = (kind == KIND_END || kind == KIND_SEP) && (key_len != '0);
    hit_k    = match_k && (key_len == LEN_W'(KW_KERNEL_LEN));
    hit_v    = match_vm && (key_len == LEN_W'(KW_VERBOSE_LEN));
    hit_vm   = match_vm && (key_len == LEN_W'(KW_VMMAP_LEN));
    unknown  = apply && !hit_k && !hit_v && !hit_vm;
    key_full = (key_len >= LEN_W'(TOKEN_MAX));
    val_full = (val_len >= LEN_W'(TOKEN_MAX));
  end

  // zero padded value, as the new module name
  always_comb begin
    for (int i = 0; i < NAME_BYTES; i++) begin
      name_copy[i] = '0;
    end
    for (int i = 0; i < NAME_BYTES && i < TOKEN_MAX; i++) begin
      if (i < int'(val_len)) name_copy[i] = value_store[i];
    end
    for (int i = 0; i < NAME_BYTES; i++) begin
      name_after[i] = (apply && hit_k) ? name_copy[i] : module_name[i];
    end
  end

  always_comb begin
    emit = 1'b0;
    ev   = EV_ACCEPT;
    if (!skipping) begin
      unique case (kind)
        KIND_END: begin
          emit = 1'b1;
          ev   = EV_ACCEPT;
        end
        KIND_SEP: begin
          emit = unknown;
          ev   = EV_UNKNOWN;
        end
        KIND_EQ: begin
          emit = in_val;
          ev   = EV_REJECT;
        end
        KIND_DATA: begin
          emit = in_val ? val_full : key_full;
          ev   = EV_REJECT;
        end
      endcase
    end
  end

  always_comb begin
    res_next.ev      = ev;
    res_next.verbose = seen_v || (apply && hit_v);
    res_next.vmmap   = seen_vm || (apply && hit_vm);
    res_next.name    = '0;
    for (int i = 0; i < NAME_BYTES && i < OUT_NAME_BYTES; i++) begin
      res_next.name[8*i +: 8] = name_after[i];
    end
  end

  // a zero always ends the line, skipping or not
  assign do_clear = pop && (kind == KIND_END);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid   <= 1'b0;
      key_len     <= '0;
      val_len     <= '0;
      in_val      <= 1'b0;
      seen_v      <= 1'b0;
      seen_vm     <= 1'b0;
      skipping    <= 1'b0;
      match_k     <= 1'b1;
      match_vm    <= 1'b1;
      module_name <= '{default: '0};
    end else begin
      if (pop && emit)    res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
      if (do_clear) begin
        key_len     <= '0;
        val_len     <= '0;
        in_val      <= 1'b0;
        seen_v      <= 1'b0;
        seen_vm     <= 1'b0;
        skipping    <= 1'b0;
        match_k     <= 1'b1;
        match_vm    <= 1'b1;
        module_name <= '{default: '0};
      end else if (pop && !skipping) begin
        case (kind)
          KIND_SEP: begin
            if (apply) begin
              if (hit_k)  module_name <= name_copy;
              if (hit_v)  seen_v <= 1'b1;
              if (hit_vm) seen_vm <= 1'b1;
              key_len  <= '0;
              val_len  <= '0;
              in_val   <= 1'b0;
              match_k  <= 1'b1;
              match_vm <= 1'b1;
            end
          end
          KIND_EQ: begin
            if (in_val) skipping <= 1'b1;
            else        in_val   <= 1'b1;
          end
          KIND_DATA: begin
            if (in_val) begin
              if (val_full) skipping <= 1'b1;
              else          val_len  <= val_len + 1'b1;
            end else begin
              if (key_full) begin
                skipping <= 1'b1;
              end else begin
                key_len  <= key_len + 1'b1;
                match_k  <= match_k && (key_len < LEN_W'(KW_KERNEL_LEN))
                            && (ch == kw_kernel_byte(key_len[2:0]));
                match_vm <= match_vm && (key_len < LEN_W'(KW_VMMAP_LEN))
                            && (ch == kw_vmmap_byte(key_len[3:0]));
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !skipping && kind == KIND_DATA && in_val && !val_full) begin
      value_store[val_len[IDX_W-1:0]] <= ch;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) res <= res_next;
  end

`ifndef SYNTHESIS
  reject_starts_skip: assert property (@(posedge clk) disable iff (rst)
    (pop && emit && ev == EV_REJECT) |=> skipping)
    else $error("reject did not start skipping");

  quiet_while_skipping: assert property (@(posedge clk) disable iff (rst)
    (pop && skipping) |-> !emit)
    else $error("result made while skipping");

  line_end_clears: assert property (@(posedge clk) disable iff (rst)
    do_clear |=> (!skipping && key_len == '0 && val_len == '0 && !in_val))
    else $error("line end did not clear state");

  lengths_bounded: assert property (@(posedge clk) disable iff (rst)
    pop |=> (key_len <= LEN_W'(TOKEN_MAX) && val_len <= LEN_W'(TOKEN_MAX)))
    else $error("token length past limit");
`endif

endmodule

FILE: rtl/boot_option_line_parser.sv
`timescale 1ns / 1ps

// Boot option line parser. Takes a command line one byte per input beat and
// sustains one byte per clock while results are taken. Space, ';' and zero
// end a token and the first '=' splits key from value. A key of kernel64
// latches its value (zero padded) as the module name, verbose and
// verbose-mmap set flags, an unknown key ended by space or ';' gives an
// unknown-option result. A zero byte gives a line-accepted result carrying
// the flags and the name, then clears everything for the next line. A second
// '=' in a token, or a key or value over 31 bytes, gives a line-rejected
// result, and later bytes give nothing until a zero, which clears quietly.
// Each byte is classified on entry and written to a four-beat queue; the
// executing stage retires one queued byte per clock, while the result
// register is free or being taken, into that result register, and the input
// keeps flowing while a result waits as long as the queue has room.
// No clearing pass after reset: the block is ready at once.
module boot_option_line_parser (
  input  logic         clk,
  input  logic         rst,
  // input bytes
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] char_byte
  // results
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [263:0] m_axis_tdata,   // [0] verbose_flag, [1] vmmap_flag,
                                       // [65:2] name_word0, [129:66] name_word1,
                                       // [193:130] name_word2, [257:194] name_word3,
                                       // [263:258] zero
  output logic [1:0]   m_axis_tuser    // [1:0] event_res
);
  import bolp_pkg::*;

  q_head_t head;
  logic    pop;
  res_t    res;

  // classify and queue
  bolp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .head     (head),
    .pop      (pop)
  );

  // token state, keyword decode and result register
  bolp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  // pack result beat, name byte 0 lowest
  assign m_axis_tdata = {6'b0, res.name, res.vmmap, res.verbose};
  assign m_axis_tuser = res.ev;

endmodule
